// File: hdl/bpc_pkg.sv
// Package for the barometric pressure compensation block.
// Types, register map and arithmetic helpers; no dependencies.
`default_nettype none
package bpc_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [2:0] RegGroupA  = 3'd0;
  localparam logic [2:0] RegGroupB  = 3'd1;
  localparam logic [2:0] RegCurveB  = 3'd2;
  localparam logic [2:0] RegTempMc  = 3'd3;
  localparam logic [2:0] RegOss     = 3'd4;

  localparam logic [31:0] PressScale = 32'd50000;
  localparam logic [31:0] B6Offset   = 32'd4000;
  localparam logic [31:0] X3Offset   = 32'd32768;
  localparam logic [31:0] PolyA      = 32'd3038;
  localparam logic [31:0] PolyB      = 32'd7357;
  localparam logic [31:0] PolyC      = 32'd3791;

  typedef struct packed {
    logic [31:0] x1;
    logic [31:0] up;
    logic        neg;
    logic        dz;
  } d1_side_t;

  typedef struct packed {
    logic [15:0] temp;
    logic        dz;
    logic        bz;
    logic        post;
  } d2_side_t;

  function automatic logic [31:0] asr32(logic [31:0] v, logic [4:0] s);
    asr32 = $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  // one restoring step: quotient bits shift into the low end of n
  function automatic logic [63:0] div_step(logic [31:0] r, logic [31:0] n, logic [31:0] d);
    logic [32:0] t;
    logic [32:0] s;
    t = {r, n[31]};
    s = t - {1'b0, d};
    if (!s[32]) begin
      div_step = {s[31:0], n[30:0], 1'b1};
    end else begin
      div_step = {t[31:0], n[30:0], 1'b0};
    end
  endfunction

endpackage
`default_nettype wire

// File: hdl/barometric_pressure_compensation.sv
// Top level: pipelined integer pressure/temperature compensation.
// Uses bpc_pkg; two 32-stage restoring dividers sit inside the pipeline.
//
// channel  | direction | payload
// s_axis   | in        | tdata[15:0] raw_temp, tdata[39:16] raw_press_bytes
// m_axis   | out       | tdata[15:0] temperature_tenths, [47:16] pressure_pa, tuser div_fault
// apb      | in/out    | 64-bit registers at 8*i, i = 0..4
//
// One transaction per cycle unless the output stalls.
// Most of the pipeline depth is in the two dividers, one quotient bit per stage each.
// Whole pipeline advances when the output register is empty or taken.
// Reset clears valid bits and calibration registers; data registers are not reset.
`default_nettype none
module barometric_pressure_compensation import bpc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // raw_temp, raw_press_bytes
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // temperature_tenths, pressure_pa
  output logic [0:0]       m_axis_tuser,   // div_fault
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int unsigned NumStages = 2 + (DivSteps + 1) + 7 + (DivSteps + 1) + 4;

  logic [47:0] grp_a_q, grp_b_q;
  logic [31:0] curve_q, mcmd_q;
  logic [1:0]  oss_q;
  logic        wr_en;
  logic [2:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_a_q <= '0;
      grp_b_q <= '0;
      curve_q <= '0;
      mcmd_q  <= '0;
      oss_q   <= '0;
    end else if (wr_en) begin
      case (idx)
        RegGroupA: grp_a_q <= pwdata[47:0];
        RegGroupB: grp_b_q <= pwdata[47:0];
        RegCurveB: curve_q <= pwdata[31:0];
        RegTempMc: mcmd_q  <= pwdata[31:0];
        RegOss:    oss_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegGroupA: prdata = {16'b0, grp_a_q};
      RegGroupB: prdata = {16'b0, grp_b_q};
      RegCurveB: prdata = {32'b0, curve_q};
      RegTempMc: prdata = {32'b0, mcmd_q};
      RegOss:    prdata = {62'b0, oss_q};
      default:   prdata = '0;
    endcase
  end

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, scale;
  assign ac1   = sx16(grp_a_q[47:32]);
  assign ac2   = sx16(grp_a_q[31:16]);
  assign ac3   = sx16(grp_a_q[15:0]);
  assign ac4   = {16'b0, grp_b_q[47:32]};
  assign ac5   = {16'b0, grp_b_q[31:16]};
  assign ac6   = {16'b0, grp_b_q[15:0]};
  assign b1    = sx16(curve_q[31:16]);
  assign b2    = sx16(curve_q[15:0]);
  assign mc    = sx16(mcmd_q[31:16]);
  assign md    = sx16(mcmd_q[15:0]);
  assign scale = PressScale >> oss_q;

  logic en;
  logic [NumStages-1:0] vld_q;

  assign en            = !vld_q[NumStages-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  // stage A
  logic [31:0] a_diff_q, a_up_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_diff_q <= {16'b0, s_axis_tdata[15:0]} - ac6;
      a_up_q   <= {8'b0, s_axis_tdata[39:16]} >> (4'd8 - {2'b0, oss_q});
    end
  end

  // stage B
  logic [31:0] b_p1_q, b_up_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_p1_q <= a_diff_q * ac5;
      b_up_q <= a_up_q;
    end
  end

  // stage C feeds temperature divider
  logic [31:0] d1_r_q [DivSteps+1];
  logic [31:0] d1_n_q [DivSteps+1];
  logic [31:0] d1_d_q [DivSteps+1];
  d1_side_t    d1_s_q [DivSteps+1];
  logic [31:0] c_x1, c_den, c_num;
  d1_side_t    c_side;

  always_comb begin
    c_x1       = asr32(b_p1_q, 5'd15);
    c_den      = c_x1 + md;
    c_num      = mc << 11;
    c_side.x1  = c_x1;
    c_side.up  = b_up_q;
    c_side.neg = c_num[31] ^ c_den[31];
    c_side.dz  = (c_den == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_r_q[0] <= '0;
      d1_n_q[0] <= c_num[31] ? (32'd0 - c_num) : c_num;
      d1_d_q[0] <= c_den[31] ? (32'd0 - c_den) : c_den;
      d1_s_q[0] <= c_side;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div1
    logic [63:0] nx;
    assign nx = div_step(d1_r_q[k], d1_n_q[k], d1_d_q[k]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        d1_r_q[k+1] <= nx[63:32];
        d1_n_q[k+1] <= nx[31:0];
        d1_d_q[k+1] <= d1_d_q[k];
        d1_s_q[k+1] <= d1_s_q[k];
      end
    end
  end

  // stage D
  logic [31:0] d_q, d_b5, d_t;
  logic [15:0] d_sat;
  logic [31:0] dd_b6_q, dd_up_q;
  logic [15:0] dd_temp_q;
  logic        dd_dz_q;

  always_comb begin
    d_q  = d1_s_q[DivSteps].neg ? (32'd0 - d1_n_q[DivSteps]) : d1_n_q[DivSteps];
    d_b5 = d1_s_q[DivSteps].x1 + d_q;
    d_t  = asr32(d_b5 + 32'd8, 5'd4);
    if ($signed(d_t) < -32'sd32768) begin
      d_sat = 16'h8000;
    end else if ($signed(d_t) > 32'sd32767) begin
      d_sat = 16'h7fff;
    end else begin
      d_sat = d_t[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_b6_q   <= d_b5 - B6Offset;
      dd_up_q   <= d1_s_q[DivSteps].up;
      dd_temp_q <= d_sat;
      dd_dz_q   <= d1_s_q[DivSteps].dz;
    end
  end

  // stage E
  logic [31:0] e_sqp_q, e_a2p_q, e_a3p_q, e_up_q;
  logic [15:0] e_temp_q;
  logic        e_dz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_sqp_q  <= dd_b6_q * dd_b6_q;
      e_a2p_q  <= ac2 * dd_b6_q;
      e_a3p_q  <= ac3 * dd_b6_q;
      e_up_q   <= dd_up_q;
      e_temp_q <= dd_temp_q;
      e_dz_q   <= dd_dz_q;
    end
  end

  // stage F
  logic [31:0] f_sq_q, f_a2s_q, f_a3s_q, f_up_q;
  logic [15:0] f_temp_q;
  logic        f_dz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_sq_q   <= asr32(e_sqp_q, 5'd12);
      f_a2s_q  <= asr32(e_a2p_q, 5'd11);
      f_a3s_q  <= asr32(e_a3p_q, 5'd13);
      f_up_q   <= e_up_q;
      f_temp_q <= e_temp_q;
      f_dz_q   <= e_dz_q;
    end
  end

  // stage G
  logic [31:0] g_b2sq_q, g_b1sq_q, g_a2s_q, g_a3s_q, g_up_q;
  logic [15:0] g_temp_q;
  logic        g_dz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      g_b2sq_q <= b2 * f_sq_q;
      g_b1sq_q <= b1 * f_sq_q;
      g_a2s_q  <= f_a2s_q;
      g_a3s_q  <= f_a3s_q;
      g_up_q   <= f_up_q;
      g_temp_q <= f_temp_q;
      g_dz_q   <= f_dz_q;
    end
  end

  // stage H
  logic [31:0] h_x3, h_b3, h_x3b;
  logic [31:0] h_b3_q, h_x3p_q, h_up_q;
  logic [15:0] h_temp_q;
  logic        h_dz_q;
  always_comb begin
    h_x3  = asr32(g_b2sq_q, 5'd11) + g_a2s_q;
    h_b3  = asr32((((ac1 << 2) + h_x3) << oss_q) + 32'd2, 5'd2);
    h_x3b = asr32(g_a3s_q + asr32(g_b1sq_q, 5'd16) + 32'd2, 5'd2);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      h_b3_q   <= h_b3;
      h_x3p_q  <= h_x3b + X3Offset;
      h_up_q   <= g_up_q;
      h_temp_q <= g_temp_q;
      h_dz_q   <= g_dz_q;
    end
  end

  // stage I
  logic [31:0] i_b4p_q, i_dup_q;
  logic [15:0] i_temp_q;
  logic        i_dz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      i_b4p_q  <= ac4 * h_x3p_q;
      i_dup_q  <= h_up_q - h_b3_q;
      i_temp_q <= h_temp_q;
      i_dz_q   <= h_dz_q;
    end
  end

  // stage J
  logic [31:0] j_b4_q, j_b7_q;
  logic [15:0] j_temp_q;
  logic        j_dz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      j_b4_q   <= i_b4p_q >> 15;
      j_b7_q   <= i_dup_q * scale;
      j_temp_q <= i_temp_q;
      j_dz_q   <= i_dz_q;
    end
  end

  // stage K feeds pressure divider
  logic [31:0] d2_r_q [DivSteps+1];
  logic [31:0] d2_n_q [DivSteps+1];
  logic [31:0] d2_d_q [DivSteps+1];
  d2_side_t    d2_s_q [DivSteps+1];
  d2_side_t    k_side;

  always_comb begin
    k_side.temp = j_temp_q;
    k_side.dz   = j_dz_q;
    k_side.bz   = (j_b4_q == '0);
    k_side.post = j_b7_q[31];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_r_q[0] <= '0;
      d2_n_q[0] <= j_b7_q[31] ? j_b7_q : (j_b7_q << 1);
      d2_d_q[0] <= j_b4_q;
      d2_s_q[0] <= k_side;
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_div2
    logic [63:0] nx;
    assign nx = div_step(d2_r_q[k], d2_n_q[k], d2_d_q[k]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        d2_r_q[k+1] <= nx[63:32];
        d2_n_q[k+1] <= nx[31:0];
        d2_d_q[k+1] <= d2_d_q[k];
        d2_s_q[k+1] <= d2_s_q[k];
      end
    end
  end

  // stage L
  logic [31:0] l_p;
  logic [31:0] l_p_q, l_pp_q;
  d2_side_t    l_s_q;
  assign l_p = d2_s_q[DivSteps].post ? (d2_n_q[DivSteps] << 1) : d2_n_q[DivSteps];
  always_ff @(posedge clk_i) begin
    if (en) begin
      l_p_q  <= l_p;
      l_pp_q <= asr32(l_p, 5'd8);
      l_s_q  <= d2_s_q[DivSteps];
    end
  end

  // stage M
  logic [31:0] m_sq_q, m_x2_q, m_p_q;
  d2_side_t    m_s_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_sq_q <= l_pp_q * l_pp_q;
      m_x2_q <= asr32((32'd0 - PolyB) * l_p_q, 5'd16);
      m_p_q  <= l_p_q;
      m_s_q  <= l_s_q;
    end
  end

  // stage N
  logic [31:0] n_x1_q, n_x2_q, n_p_q;
  d2_side_t    n_s_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      n_x1_q <= asr32(m_sq_q * PolyA, 5'd16);
      n_x2_q <= m_x2_q;
      n_p_q  <= m_p_q;
      n_s_q  <= m_s_q;
    end
  end

  // stage O: output register
  logic [31:0] o_p;
  logic [15:0] out_temp_q;
  logic [31:0] out_press_q;
  logic        out_fault_q;
  assign o_p = n_p_q + asr32(n_x1_q + n_x2_q + PolyC, 5'd4);
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_temp_q  <= n_s_q.dz ? 16'd0 : n_s_q.temp;
      out_press_q <= (n_s_q.dz || n_s_q.bz) ? 32'd0 : o_p;
      out_fault_q <= n_s_q.dz || n_s_q.bz;
    end
  end

  assign m_axis_tdata = {out_press_q, out_temp_q};
  assign m_axis_tuser = out_fault_q;

endmodule
`default_nettype wire

// File: hdl/bpc_checker.sv
// Port-level checker for the compensation block, bound to the top level.
// Sees only the top level's ports; no package dependency.
`default_nettype none
module bpc_props (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser,
  input wire logic        pready
);

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[47:16] == 32'd0)
    else $error("fault with nonzero pressure");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output drain");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind barometric_pressure_compensation bpc_props u_bpc_checker (.*);
`default_nettype wire

// File: test/bpc_checker.sv
// Checker for the barometric pressure compensation block.
// Watches both stream channels and the register port, predicts results; uses bpc_pkg.
`default_nettype none
module bpc_checker import bpc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,
  input  wire logic [0:0]  m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending,
  output int               result_count,
  output int               fault_count
);

  typedef struct packed {
    logic [15:0] temp;
    logic [31:0] press;
    logic        fault;
  } reading_t;

  logic [47:0] grp_a, grp_b;
  logic [31:0] curve_b, mc_md;
  logic [1:0]  oss;
  reading_t    readings_due[$];

  function automatic logic [31:0] shr_s(logic [31:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sext(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] trunc_div(logic [31:0] n, logic [31:0] d);
    logic [31:0] an, ad, q;
    an = n[31] ? -n : n;
    ad = d[31] ? -d : d;
    q  = an / ad;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  function automatic reading_t compensate(logic [15:0] ut_raw, logic [23:0] up_raw);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, b3, b4, b5, b6, b7, p, sq, den, t;
    reading_t r;
    ac1 = sext(grp_a[47:32]); ac2 = sext(grp_a[31:16]); ac3 = sext(grp_a[15:0]);
    ac4 = {16'd0, grp_b[47:32]}; ac5 = {16'd0, grp_b[31:16]}; ac6 = {16'd0, grp_b[15:0]};
    b1 = sext(curve_b[31:16]); b2 = sext(curve_b[15:0]);
    mc = sext(mc_md[31:16]); md = sext(mc_md[15:0]);
    ut = {16'd0, ut_raw};
    up = {8'd0, up_raw} >> (8 - oss);
    r = '0;
    x1 = shr_s((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.fault = 1'b1;
      return r;
    end
    x2 = trunc_div(mc << 11, den);
    b5 = x1 + x2;
    t = shr_s(b5 + 8, 4);
    if ($signed(t) < -32768) r.temp = 16'h8000;
    else if ($signed(t) > 32767) r.temp = 16'h7fff;
    else r.temp = t[15:0];
    b6 = b5 - 32'd4000;
    sq = shr_s(b6 * b6, 12);
    x1 = shr_s(b2 * sq, 11);
    x2 = shr_s(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = shr_s(((ac1 * 4 + x3) << oss) + 2, 2);
    x1 = shr_s(ac3 * b6, 13);
    x2 = shr_s(b1 * sq, 16);
    x3 = shr_s(x1 + x2 + 2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    b7 = (up - b3) * (32'd50000 >> oss);
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = shr_s(p, 8) * shr_s(p, 8);
    x1 = shr_s(x1 * 32'd3038, 16);
    x2 = shr_s(-32'd7357 * p, 16);
    r.press = p + shr_s(x1 + x2 + 32'd3791, 4);
    return r;
  endfunction

  assign pending = readings_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want, got;
    if (!rst_ni) begin
      grp_a <= '0; grp_b <= '0; curve_b <= '0; mc_md <= '0; oss <= '0;
      fail_count <= 0; result_count <= 0; fault_count <= 0;
      readings_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[5:3])
          RegGroupA: grp_a   <= pwdata[47:0];
          RegGroupB: grp_b   <= pwdata[47:0];
          RegCurveB: curve_b <= pwdata[31:0];
          RegTempMc: mc_md   <= pwdata[31:0];
          RegOss:    oss     <= pwdata[1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[47:16], m_axis_tuser[0]};
        result_count <= result_count + 1;
        if (got.fault) fault_count <= fault_count + 1;
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = readings_due.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch temp exp %0d got %0d, press exp %0d got %0d, fault exp %b got %b",
                     $time, $signed(want.temp), $signed(got.temp), $signed(want.press),
                     $signed(got.press), want.fault, got.fault);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        readings_due.push_back(compensate(s_axis_tdata[15:0], s_axis_tdata[39:16]));
    end
  end

endmodule
`default_nettype wire

// File: test/testbench.sv
// Top of the compensation testbench: clock, reset, stimulus, stall control, verdict.
// Depends on bpc_pkg, barometric_pressure_compensation and bpc_checker.
`default_nettype none
module testbench import bpc_pkg::*;;

  localparam int Latency = 79;
  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count, pending, result_count, fault_count;
  int          cycles = 0;
  int          sample_total = 0;
  bit          hold_output = 1'b0;

  always #5 clk_i = ~clk_i;

  barometric_pressure_compensation i_dut (.*);

  bpc_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending, .result_count, .fault_count
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        if (n == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          repeat (n) @(negedge clk_i);
          m_axis_tready <= 1'b1;
        end
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // tvalid stays high between back-to-back transactions; drain() drops it
  task automatic send_sample(logic [15:0] ut, logic [23:0] up, bit paced);
    int n;
    n = paced ? gap_len() : 0;
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {up, ut};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sample_total++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  // typical factory calibration set
  task automatic load_typical(logic [1:0] os);
    reg_write(RegGroupA, {16'd0, 16'sd408, -16'sd72, -16'sd14383});
    reg_write(RegGroupB, {16'd0, 16'd32741, 16'd32757, 16'd23153});
    reg_write(RegCurveB, {32'd0, 16'sd6190, 16'sd4});
    reg_write(RegTempMc, {32'd0, -16'sd8711, 16'sd2868});
    reg_write(RegOss, {62'd0, os});
  endtask

  task automatic load_random();
    reg_write(RegGroupA, {$urandom, $urandom});
    reg_write(RegGroupB, {$urandom, $urandom});
    reg_write(RegCurveB, {32'd0, $urandom});
    reg_write(RegTempMc, {32'd0, $urandom});
    reg_write(RegOss, {$urandom, $urandom});
  endtask

  task automatic random_typical(bit paced);
    logic [15:0] ut;
    ut = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(20000, 35000));
    send_sample(ut, ($urandom_range(0, 9) == 0) ? 24'($urandom) :
                24'($urandom_range(24'h500000, 24'hB00000)), paced);
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero calibration: temperature divisor is zero
    send_sample(16'h0000, 24'h000000, 1'b0);
    send_sample(16'hffff, 24'hffffff, 1'b0);
    drain();

    // pressure divisor zero: ac4 = 0
    reg_write(RegTempMc, {32'd0, 16'h0001, 16'h0001});
    send_sample(16'h1234, 24'h5a5a5a, 1'b0);
    send_sample(16'hedcb, 24'ha5a5a5, 1'b0);
    drain();

    // temperature divisor zero with ac5 = 0 and md = 0
    reg_write(RegTempMc, {32'd0, 16'h7fff, 16'h0000});
    send_sample(16'h8000, 24'h800000, 1'b0);
    drain();

    for (int os = 0; os < 4; os++) begin
      load_typical(2'(os));
      send_sample(16'd27898, 24'h5d2300, 1'b0);
      send_sample(16'h0000, 24'h000000, 1'b0);
      send_sample(16'hffff, 24'hffffff, 1'b0);
      send_sample(16'h7fff, 24'h800000, 1'b0);
      drain();
    end

    // extreme calibration: saturating temperatures, wrapping pressures
    reg_write(RegGroupA, {16'd0, 48'hffff_ffff_ffff});
    reg_write(RegGroupB, {16'd0, 48'hffff_ffff_0000});
    reg_write(RegCurveB, {32'd0, 32'h7fff_8000});
    reg_write(RegTempMc, {32'd0, 32'h7fff_0001});
    send_sample(16'hffff, 24'hffffff, 1'b0);
    send_sample(16'h0001, 24'h000001, 1'b0);
    drain();
    reg_write(RegTempMc, {32'd0, 32'h8000_0001});
    send_sample(16'hffff, 24'hffffff, 1'b0);
    send_sample(16'h0000, 24'h000000, 1'b0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 2 == 0) load_typical(2'($urandom));
      else load_random();
      if (phase == 3) begin
        hold_output = 1'b1;
        fork
          begin
            repeat (200) @(negedge clk_i);
            hold_output = 1'b0;
          end
          repeat (150) random_typical(1'b0);
        join
      end
      repeat (190) random_typical(1'b1);
      if (phase == 5) drain();
      repeat (20) send_sample(16'($urandom), 24'($urandom), 1'b1);
      drain();
    end

    $display("Sent %0d samples, checked %0d results, %0d with a divide fault",
             sample_total, result_count, fault_count);
    $display("Calibration sets: typical at every oversampling, random and extreme words");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
